// ===== src/dpcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Disk/plane contact gap package
// Shared widths, the pipeline sideband word and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcg_pkg;

    // Sum of squared Q.28 components, and its integer square root.
    localparam int SQ_W        = 62;
    localparam int ROOT_W      = 31;
    localparam int SQRT_STEPS  = 31;
    localparam int SQRT_ACC_W  = 63;

    // Divider: numerator r*|z_i| + |z|/2, quotient at most r + 1.
    localparam int NUM_W       = 62;
    localparam int QUO_W       = 32;
    localparam int DIV_STEPS   = 32;

    localparam int RADIUS_W    = 31;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

    // Clamp applied to each z component, and the parallel threshold on |z|^2.
    localparam logic signed [37:0] Z_LIMIT_POS = 38'sd1073741824;
    localparam logic signed [37:0] Z_LIMIT_NEG = -38'sd1073741824;
    localparam logic [SQ_W-1:0]    PARALLEL_SQ_LIMIT = 62'd7;

    // Sideband word that travels alongside the arithmetic.
    typedef struct packed {
        logic [2:0][15:0]         n;
        logic [2:0][31:0]         o;
        logic [2:0][31:0]         c;
        logic [2:0]               z_neg;
        logic [2:0][ROOT_W-1:0]   mag;
        logic                     parallel;
    } item_t;

    // Saturate a wide signed value to 32-bit signed.
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        begin
            if (v > 64'sd2147483647)
            begin
                r = 32'h7FFF_FFFF;
            end
            else if (v < -64'sd2147483648)
            begin
                r = 32'h8000_0000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/dpcg_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit resolved per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcg_sqrt
    import dpcg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SQ_W-1:0]   radicand,
    input  wire item_t             in_item,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output item_t                  out_item
);

    logic                  v_reg    [0:SQRT_STEPS-1];
    logic [SQRT_ACC_W-1:0] x_reg    [0:SQRT_STEPS-1];
    logic [SQRT_ACC_W-1:0] r_reg    [0:SQRT_STEPS-1];
    item_t                 item_reg [0:SQRT_STEPS-1];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [SQRT_ACC_W-1:0] BIT =
            SQRT_ACC_W'(1) << (2 * (SQRT_STEPS - 1 - s));

        logic                  v_in;
        logic [SQRT_ACC_W-1:0] x_in;
        logic [SQRT_ACC_W-1:0] r_in;
        item_t                 item_in;
        logic [SQRT_ACC_W-1:0] trial;
        logic [SQRT_ACC_W-1:0] x_next;
        logic [SQRT_ACC_W-1:0] r_next;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign x_in    = SQRT_ACC_W'(radicand);
            assign r_in    = '0;
            assign item_in = in_item;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign r_in    = r_reg[s-1];
            assign item_in = item_reg[s-1];
        end

        // One restoring step: try to set this bit of the root.
        always_comb
        begin
            trial = r_in + BIT;
            if (x_in >= trial)
            begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        // Working words of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_next;
                r_reg[s]    <= r_next;
                item_reg[s] <= item_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign root      = r_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_item  = item_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== src/dpcg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcg_div
    import dpcg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [2:0][NUM_W-1:0]   num,
    input  wire logic [ROOT_W-1:0]       den,
    input  wire item_t                   in_item,
    output logic                         out_valid,
    output logic [2:0][QUO_W-1:0]        quo,
    output item_t                        out_item
);

    logic                      v_reg    [0:DIV_STEPS-1];
    logic [2:0][ROOT_W-1:0]    rem_reg  [0:DIV_STEPS-1];
    logic [2:0][QUO_W-1:0]     low_reg  [0:DIV_STEPS-1];
    logic [2:0][QUO_W-1:0]     q_reg    [0:DIV_STEPS-1];
    logic [ROOT_W-1:0]         den_reg  [0:DIV_STEPS-1];
    item_t                     item_reg [0:DIV_STEPS-1];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic                   v_in;
        logic [2:0][ROOT_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0]  low_in;
        logic [2:0][QUO_W-1:0]  q_in;
        logic [ROOT_W-1:0]      den_in;
        item_t                  item_in;
        logic [2:0][ROOT_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0]  low_next;
        logic [2:0][QUO_W-1:0]  q_next;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = ROOT_W'(num[i][NUM_W-1:QUO_W]);
                    low_in[i] = num[i][QUO_W-1:0];
                end
            end
            assign v_in    = in_valid;
            assign q_in    = '0;
            assign den_in  = den;
            assign item_in = in_item;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign low_in  = low_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign item_in = item_reg[s-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        always_comb
        begin
            logic [ROOT_W:0] trial;
            logic            ge;
            for (int i = 0; i < 3; i++)
            begin
                trial = {rem_in[i], low_in[i][QUO_W-1]};
                ge    = (trial >= {1'b0, den_in});
                if (ge)
                begin
                    rem_next[i] = ROOT_W'(trial - {1'b0, den_in});
                end
                else
                begin
                    rem_next[i] = trial[ROOT_W-1:0];
                end
                low_next[i] = low_in[i] << 1;
                q_next[i]   = {q_in[i][QUO_W-2:0], ge};
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        // Working words of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                low_reg[s]  <= low_next;
                q_reg[s]    <= q_next;
                den_reg[s]  <= den_in;
                item_reg[s] <= item_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign quo       = q_reg[DIV_STEPS-1];
    assign out_item  = item_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== src/disk_plane_contact_gap_top.sv =====
// Throughput: one word per cycle while out_ready does not stall the output; the 31-stage square root
// and the 32-stage divider each resolve one bit per stage.
// The whole pipeline stalls as one while the output word waits for out_ready.
// Reset clears every valid bit and loads the disk radius with 1.0 (Q16.16).
// ----------------------------------------------------------------------------
// Disk/plane contact gap
// Closest disk rim point to a plane, its projection and the signed gap.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_plane_contact_gap_top
    import dpcg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [RADIUS_W-1:0]  cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   normal_x,
    input  wire logic signed [15:0]   normal_y,
    input  wire logic signed [15:0]   normal_z,
    input  wire logic signed [31:0]   plane_origin_x,
    input  wire logic signed [31:0]   plane_origin_y,
    input  wire logic signed [31:0]   plane_origin_z,
    input  wire logic signed [31:0]   center_x,
    input  wire logic signed [31:0]   center_y,
    input  wire logic signed [31:0]   center_z,
    input  wire logic signed [15:0]   axis_x,
    input  wire logic signed [15:0]   axis_y,
    input  wire logic signed [15:0]   axis_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        gap,
    output logic signed [31:0]        disk_point_x,
    output logic signed [31:0]        disk_point_y,
    output logic signed [31:0]        disk_point_z,
    output logic signed [31:0]        plane_point_x,
    output logic signed [31:0]        plane_point_y,
    output logic signed [31:0]        plane_point_z,
    output logic                      parallel_flag
);

    logic                  en;
    logic [RADIUS_W-1:0]   radius_reg;

    logic [7:1]            pre_v_reg;
    item_t                 s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    item_t                 s5_item_reg, s6_item_reg, s7_item_reg;
    logic [2:0][15:0]      s1_b_reg, s2_b_reg;
    logic [2:0][31:0]      s2_nb_reg;
    logic signed [33:0]    s3_t_reg;
    logic [2:0][16:0]      s3_bf_reg;
    logic [2:0][50:0]      s4_tb_reg;
    logic [2:0][31:0]      s5_z_reg;
    logic [2:0][60:0]      s6_zsq_reg;
    logic [SQ_W-1:0]       s7_sq_reg;

    logic                  sq_v;
    logic [ROOT_W-1:0]     sq_root;
    item_t                 sq_item;

    logic                  s8_v_reg;
    logic [2:0][NUM_W-1:0] s8_num_reg;
    logic [ROOT_W-1:0]     s8_den_reg;
    item_t                 s8_item_reg;

    logic                  dv_v;
    logic [2:0][QUO_W-1:0] dv_q;
    item_t                 dv_item;

    logic [14:9]           post_v_reg;
    item_t                 s9_item_reg, s10_item_reg, s11_item_reg, s12_item_reg;
    item_t                 s13_item_reg;
    logic [2:0][33:0]      s9_p_reg, s10_p_reg, s11_p_reg, s12_p_reg, s13_p_reg;
    logic [2:0][34:0]      s10_po_reg;
    logic [2:0][50:0]      s11_g_reg;
    logic [38:0]           s12_gap_reg, s13_gap_reg;
    logic [2:0][54:0]      s13_ng_reg;

    logic [2:0][31:0]      nb_c;
    logic signed [33:0]    t_c;
    logic [2:0][16:0]      bf_c;
    logic [2:0][50:0]      tb_c;
    logic [2:0][31:0]      z_c;
    logic [2:0][60:0]      zsq_c;
    logic [2:0][ROOT_W-1:0] mag_c;
    logic [2:0]            zneg_c;
    logic [SQ_W-1:0]       sq_c;
    item_t                 s6_item_c;
    item_t                 s7_item_c;
    logic [2:0][NUM_W-1:0] num_c;
    logic [2:0][33:0]      p_c;
    logic [2:0][34:0]      po_c;
    logic [2:0][50:0]      g_c;
    logic [38:0]           gap_c;
    logic [2:0][54:0]      ng_c;
    logic [31:0]           gap_o;
    logic [2:0][31:0]      dp_o;
    logic [2:0][31:0]      pp_o;
    item_t                 in_item;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Disk radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Input word as sideband.
    always_comb
    begin
        in_item          = '0;
        in_item.n[0]     = normal_x;
        in_item.n[1]     = normal_y;
        in_item.n[2]     = normal_z;
        in_item.o[0]     = plane_origin_x;
        in_item.o[1]     = plane_origin_y;
        in_item.o[2]     = plane_origin_z;
        in_item.c[0]     = center_x;
        in_item.c[1]     = center_y;
        in_item.c[2]     = center_z;
    end

    // Front-end arithmetic: n.b, axis flip, z = n - t*b, |z|^2.
    always_comb
    begin
        logic signed [33:0] t_raw;
        logic signed [36:0] rnd;
        logic signed [37:0] zw;
        logic signed [63:0] sq64;
        for (int i = 0; i < 3; i++)
        begin
            nb_c[i] = $signed(s1_item_reg.n[i]) * $signed(s1_b_reg[i]);
        end

        t_raw = 34'($signed(s2_nb_reg[0])) + 34'($signed(s2_nb_reg[1]))
              + 34'($signed(s2_nb_reg[2]));
        t_c = (t_raw > 34'sd0) ? -t_raw : t_raw;
        for (int i = 0; i < 3; i++)
        begin
            if (t_raw > 34'sd0)
            begin
                bf_c[i] = -17'($signed(s2_b_reg[i]));
            end
            else
            begin
                bf_c[i] = 17'($signed(s2_b_reg[i]));
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            tb_c[i] = $signed(s3_t_reg) * $signed(s3_bf_reg[i]);
        end

        for (int i = 0; i < 3; i++)
        begin
            rnd = 37'(($signed(s4_tb_reg[i]) + 51'sd8192) >>> 14);
            zw  = (38'($signed(s4_item_reg.n[i])) <<< 14) - 38'(rnd);
            if (zw > Z_LIMIT_POS)
            begin
                z_c[i] = 32'(Z_LIMIT_POS);
            end
            else if (zw < Z_LIMIT_NEG)
            begin
                z_c[i] = 32'(Z_LIMIT_NEG);
            end
            else
            begin
                z_c[i] = zw[31:0];
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            sq64      = $signed(s5_z_reg[i]) * $signed(s5_z_reg[i]);
            zsq_c[i]  = sq64[60:0];
            zneg_c[i] = s5_z_reg[i][31];
            mag_c[i]  = zneg_c[i] ? ROOT_W'(-s5_z_reg[i]) : s5_z_reg[i][ROOT_W-1:0];
        end

        sq_c = SQ_W'(s6_zsq_reg[0]) + SQ_W'(s6_zsq_reg[1]) + SQ_W'(s6_zsq_reg[2]);

        // Sideband words gain the sign and magnitude of z, then the parallel flag.
        s6_item_c       = s5_item_reg;
        s6_item_c.z_neg = zneg_c;
        s6_item_c.mag   = mag_c;

        s7_item_c          = s6_item_reg;
        s7_item_c.parallel = (sq_c <= PARALLEL_SQ_LIMIT);
    end

    // Front-end pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= '0;
        end
        else if (en)
        begin
            pre_v_reg <= {pre_v_reg[6:1], in_valid};
        end
    end

    // Front-end pipeline words.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= in_item;
            s1_b_reg    <= {axis_z, axis_y, axis_x};

            s2_item_reg <= s1_item_reg;
            s2_b_reg    <= s1_b_reg;
            s2_nb_reg   <= nb_c;

            s3_item_reg <= s2_item_reg;
            s3_t_reg    <= t_c;
            s3_bf_reg   <= bf_c;

            s4_item_reg <= s3_item_reg;
            s4_tb_reg   <= tb_c;

            s5_item_reg <= s4_item_reg;
            s5_z_reg    <= z_c;

            s6_item_reg <= s6_item_c;
            s6_zsq_reg  <= zsq_c;

            s7_item_reg <= s7_item_c;
            s7_sq_reg   <= sq_c;
        end
    end

    dpcg_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_v_reg[7]),
        .radicand  (s7_sq_reg),
        .in_item   (s7_item_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_item  (sq_item)
    );

    // Rounded numerators r*|z_i| + |z|/2.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_c[i] = NUM_W'(radius_reg) * NUM_W'(sq_item.mag[i]) + NUM_W'(sq_root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_num_reg  <= num_c;
            s8_den_reg  <= sq_root;
            s8_item_reg <= sq_item;
        end
    end

    dpcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s8_v_reg),
        .num       (s8_num_reg),
        .den       (s8_den_reg),
        .in_item   (s8_item_reg),
        .out_valid (dv_v),
        .quo       (dv_q),
        .out_item  (dv_item)
    );

    // Back-end arithmetic: disk point, gap and plane projection.
    always_comb
    begin
        logic signed [33:0] qs;
        logic signed [52:0] gsum;
        logic signed [40:0] rnd;
        logic signed [41:0] pp;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed({2'b00, dv_q[i]});
            if (dv_item.parallel)
            begin
                p_c[i] = 34'($signed(dv_item.c[i]));
            end
            else if (dv_item.z_neg[i])
            begin
                p_c[i] = 34'($signed(dv_item.c[i])) + qs;
            end
            else
            begin
                p_c[i] = 34'($signed(dv_item.c[i])) - qs;
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            po_c[i] = 35'($signed(s9_p_reg[i])) - 35'($signed(s9_item_reg.o[i]));
            g_c[i]  = $signed(s10_item_reg.n[i]) * $signed(s10_po_reg[i]);
        end

        gsum  = 53'($signed(s11_g_reg[0])) + 53'($signed(s11_g_reg[1]))
              + 53'($signed(s11_g_reg[2]));
        gap_c = 39'((gsum + 53'sd8192) >>> 14);

        for (int i = 0; i < 3; i++)
        begin
            ng_c[i] = $signed(s12_item_reg.n[i]) * $signed(s12_gap_reg);
        end

        gap_o = sat32(64'($signed(s13_gap_reg)));
        for (int i = 0; i < 3; i++)
        begin
            rnd     = 41'(($signed(s13_ng_reg[i]) + 55'sd8192) >>> 14);
            pp      = 42'($signed(s13_p_reg[i])) - 42'(rnd);
            dp_o[i] = sat32(64'($signed(s13_p_reg[i])));
            pp_o[i] = sat32(64'(pp));
        end
    end

    // Back-end valid bits; the last one is the output word's valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_v_reg <= '0;
        end
        else if (en)
        begin
            post_v_reg <= {post_v_reg[13:9], dv_v};
        end
    end

    // Back-end words and the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_item_reg  <= dv_item;
            s9_p_reg     <= p_c;

            s10_item_reg <= s9_item_reg;
            s10_p_reg    <= s9_p_reg;
            s10_po_reg   <= po_c;

            s11_item_reg <= s10_item_reg;
            s11_p_reg    <= s10_p_reg;
            s11_g_reg    <= g_c;

            s12_item_reg <= s11_item_reg;
            s12_p_reg    <= s11_p_reg;
            s12_gap_reg  <= gap_c;

            s13_item_reg <= s12_item_reg;
            s13_p_reg    <= s12_p_reg;
            s13_gap_reg  <= s12_gap_reg;
            s13_ng_reg   <= ng_c;

            gap           <= gap_o;
            disk_point_x  <= dp_o[0];
            disk_point_y  <= dp_o[1];
            disk_point_z  <= dp_o[2];
            plane_point_x <= pp_o[0];
            plane_point_y <= pp_o[1];
            plane_point_z <= pp_o[2];
            parallel_flag <= s13_item_reg.parallel;
        end
    end

    assign out_valid = post_v_reg[14];

    // A parallel disk keeps its centre as the contact point (the x and z components are checked).
    a_parallel_centre: assert property (@(posedge clk) disable iff (!rst_n)
        post_v_reg[9] && s9_item_reg.parallel |->
            ($signed(s9_p_reg[0]) == 34'($signed(s9_item_reg.c[0])))
            && ($signed(s9_p_reg[2]) == 34'($signed(s9_item_reg.c[2]))))
        else $error("parallel disk point differs from centre");

    // The rim offset never exceeds the radius plus one rounding step.
    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v && !dv_item.parallel |->
            (dv_q[0] <= 32'(radius_reg) + 32'd1) && (dv_q[1] <= 32'(radius_reg) + 32'd1)
            && (dv_q[2] <= 32'(radius_reg) + 32'd1))
        else $error("divider quotient above radius bound");

    // A stalled output freezes the whole pipeline; the front-end, s8 and back-end valid bits are checked.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(post_v_reg) && $stable(pre_v_reg)
            && $stable(s8_v_reg))
        else $error("pipeline moved during an output stall");

    // A non-parallel word has a non-zero norm for the divider.
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v && !sq_item.parallel |-> (sq_root != '0))
        else $error("zero norm on a non-parallel word");

endmodule

`default_nettype wire
